// File: hdl/rtiuv_pkg.sv
// ----------------------------------------------------------------------------
// rtiuv_pkg
// Shared widths, types and codes of the ray / triangle intersection block
// ----------------------------------------------------------------------------
package rtiuv_pkg;

	localparam int VERTEX_COUNT = 1024;
	localparam int ADDR_W       = $clog2(VERTEX_COUNT);
	localparam int IDX_W        = 10;
	localparam int FRAC_BITS    = 16;

	localparam int COORD_W = 32;
	localparam int TEX_W   = 16;
	localparam int DIST_W  = 31;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int MINOR_W = PROD_W + 1;
	localparam int MUL_A_W = DIFF_W;
	localparam int MUL_B_W = 104;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DET_W   = 104;
	localparam int QUO_W   = DIST_W;
	localparam int DIV_W   = DET_W + QUO_W - 1;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TEST = 1'b1;

	localparam logic REG_MIN_DISTANCE = 1'b0;
	localparam logic [DIST_W-1:0] MIN_DIST_RESET = DIST_W'(7);
	localparam logic [DIST_W-1:0] DIST_SAT = '1;

	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
		logic [TEX_W-1:0]          tu;
		logic [TEX_W-1:0]          tv;
	} vertex_t;

	typedef struct packed {
		logic [TEX_W-1:0] tu0;
		logic [TEX_W-1:0] tv0;
		logic [TEX_W-1:0] tu1;
		logic [TEX_W-1:0] tv1;
		logic [TEX_W-1:0] tu2;
		logic [TEX_W-1:0] tv2;
	} tex_t;

	typedef struct packed {
		logic vld;
		logic miss;
		logic sat;
	} meta_t;

endpackage

// File: hdl/rtiuv_ram.sv
// ----------------------------------------------------------------------------
// rtiuv_ram
// Vertex store copy: one write port, one registered read port
// ----------------------------------------------------------------------------
module rtiuv_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [rtiuv_pkg::ADDR_W-1:0] waddr,
	input  rtiuv_pkg::vertex_t           wdata,
	input  logic                         re,
	input  logic [rtiuv_pkg::ADDR_W-1:0] raddr,
	output rtiuv_pkg::vertex_t           rdata
);

	rtiuv_pkg::vertex_t mem [rtiuv_pkg::VERTEX_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/rtiuv_mul.sv
// ----------------------------------------------------------------------------
// rtiuv_mul
// Two-stage signed multiplier: 32-bit slices and an 8-bit top slice of the wide operand, then a sum
// ----------------------------------------------------------------------------
module rtiuv_mul (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [rtiuv_pkg::MUL_A_W-1:0] a,
	input  logic signed [rtiuv_pkg::MUL_B_W-1:0] b,
	output logic signed [rtiuv_pkg::MUL_P_W-1:0] p
);

	localparam int AW = rtiuv_pkg::MUL_A_W;
	localparam int PW = rtiuv_pkg::MUL_P_W;

	logic signed [AW+32:0] pp0_s1, pp1_s1, pp2_s1;
	logic signed [AW+7:0]  pp3_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pp0_s1 <= a * $signed({1'b0, b[31:0]});
			pp1_s1 <= a * $signed({1'b0, b[63:32]});
			pp2_s1 <= a * $signed({1'b0, b[95:64]});
			pp3_s1 <= a * $signed(b[103:96]);
			p      <= PW'(pp0_s1) + (PW'(pp1_s1) <<< 32) + (PW'(pp2_s1) <<< 64)
				+ (PW'(pp3_s1) <<< 96);
		end
	end

endmodule

// File: hdl/rtiuv_div.sv
// ----------------------------------------------------------------------------
// rtiuv_div
// Pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module rtiuv_div (
	input  logic                               clk,
	input  logic                               en,
	input  logic [rtiuv_pkg::DIV_W-1:0]        num,
	input  logic [rtiuv_pkg::DET_W-1:0]        den,
	output logic [rtiuv_pkg::QUO_W-1:0]        quo
);

	localparam int QW = rtiuv_pkg::QUO_W;
	localparam int NW = rtiuv_pkg::DIV_W;
	localparam int DW = rtiuv_pkg::DET_W;

	logic [NW-1:0] rem_q [QW];
	logic [DW-1:0] den_q [QW];
	logic [QW-1:0] quo_q [QW];

	for (genvar g = 0; g < QW; g++) begin : g_stage
		localparam int B = QW - 1 - g;
		logic [NW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic [NW:0]   trial;

		if (g == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[g-1];
			assign den_in = den_q[g-1];
			assign quo_in = quo_q[g-1];
		end

		assign trial = {1'b0, rem_in} - ((NW+1)'(den_in) << B);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g] <= trial[NW] ? rem_in : trial[NW-1:0];
				den_q[g] <= den_in;
				quo_q[g] <= {quo_in[QW-2:0], ~trial[NW]};
			end
		end
	end

	assign quo = quo_q[QW-1];

endmodule

// File: hdl/ray_triangle_intersect_uv.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect_uv
// Ray / triangle test by Cramer's rule with barycentric texture blend
// ----------------------------------------------------------------------------
// One word is taken every cycle unless the pipeline stalls. A load word
// writes one vertex into three copies of the vertex store (one per triangle
// corner read port) and gives no result. A test word passes through twelve
// stages of store read, differences, minors, determinants and texture
// products, then the 31-stage restoring dividers for distance and u,v, then
// the output register. The pipeline stalls only while a result waits at the
// output and the next one reaches the end of the dividers.
module ray_triangle_intersect_uv (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic [rtiuv_pkg::IDX_W-1:0]         idx0,
	input  logic [rtiuv_pkg::IDX_W-1:0]         idx1,
	input  logic [rtiuv_pkg::IDX_W-1:0]         idx2,
	input  logic signed [rtiuv_pkg::COORD_W-1:0] pos_x,
	input  logic signed [rtiuv_pkg::COORD_W-1:0] pos_y,
	input  logic signed [rtiuv_pkg::COORD_W-1:0] pos_z,
	input  logic signed [rtiuv_pkg::COORD_W-1:0] dir_x,
	input  logic signed [rtiuv_pkg::COORD_W-1:0] dir_y,
	input  logic signed [rtiuv_pkg::COORD_W-1:0] dir_z,
	input  logic [rtiuv_pkg::TEX_W-1:0]         tex_u,
	input  logic [rtiuv_pkg::TEX_W-1:0]         tex_v,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic [rtiuv_pkg::DIST_W-1:0]        dist_t,
	output logic [rtiuv_pkg::TEX_W-1:0]         hit_u,
	output logic [rtiuv_pkg::TEX_W-1:0]         hit_v
);

	localparam int CW = rtiuv_pkg::COORD_W;
	localparam int FW = rtiuv_pkg::DIFF_W;
	localparam int PW = rtiuv_pkg::PROD_W;
	localparam int MW = rtiuv_pkg::MINOR_W;
	localparam int AW = rtiuv_pkg::MUL_A_W;
	localparam int BW = rtiuv_pkg::MUL_B_W;
	localparam int XW = rtiuv_pkg::MUL_P_W;
	localparam int DW = rtiuv_pkg::DET_W;
	localparam int NW = rtiuv_pkg::DIV_W;
	localparam int QW = rtiuv_pkg::QUO_W;
	localparam int SW = DW + rtiuv_pkg::DIST_W;

	// configuration
	logic [rtiuv_pkg::DIST_W-1:0] min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= rtiuv_pkg::MIN_DIST_RESET;
		end else if (psel && penable && pwrite && paddr[2] == rtiuv_pkg::REG_MIN_DISTANCE) begin
			min_q <= pwdata[rtiuv_pkg::DIST_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == rtiuv_pkg::REG_MIN_DISTANCE) ? 32'(min_q) : '0;

	// flow control
	logic  en;
	logic  out_valid_q;
	rtiuv_pkg::meta_t meta_q [QW];
	rtiuv_pkg::meta_t last;

	assign last     = meta_q[QW-1];
	assign en       = !(last.vld && out_valid_q && !out_ready);
	assign in_ready = en;

	// vertex store copies
	rtiuv_pkg::vertex_t wvert, v0_s1, v1_s1, v2_s1;
	logic               we;

	assign we    = in_valid && en && req_type == rtiuv_pkg::REQ_LOAD;
	assign wvert = '{px: pos_x, py: pos_y, pz: pos_z, tu: tex_u, tv: tex_v};

	rtiuv_ram u_ram0 (.clk(clk), .we(we), .waddr(idx0[rtiuv_pkg::ADDR_W-1:0]), .wdata(wvert),
		.re(en), .raddr(idx0[rtiuv_pkg::ADDR_W-1:0]), .rdata(v0_s1));
	rtiuv_ram u_ram1 (.clk(clk), .we(we), .waddr(idx0[rtiuv_pkg::ADDR_W-1:0]), .wdata(wvert),
		.re(en), .raddr(idx1[rtiuv_pkg::ADDR_W-1:0]), .rdata(v1_s1));
	rtiuv_ram u_ram2 (.clk(clk), .we(we), .waddr(idx0[rtiuv_pkg::ADDR_W-1:0]), .wdata(wvert),
		.re(en), .raddr(idx2[rtiuv_pkg::ADDR_W-1:0]), .rdata(v2_s1));

	// valid chain
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_s10, vld_s11, vld_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6} <= '0;
			{vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12} <= '0;
		end else if (en) begin
			vld_s1  <= in_valid && req_type == rtiuv_pkg::REQ_TEST;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	// datapath
	logic signed [CW-1:0] ogx_s1, ogy_s1, ogz_s1, dx_s1, dy_s1, dz_s1;
	logic signed [FW-1:0] ax_s2, ay_s2, az_s2, bx_s2, by_s2, bz_s2;
	logic signed [FW-1:0] ox_s2, oy_s2, oz_s2, dx_s2, dy_s2, dz_s2;
	logic signed [FW-1:0] ax_s3, bx_s3, dx_s3, ox_s3, ax_s4, bx_s4, dx_s4, ox_s4;
	logic signed [PW-1:0] pr_s3 [12];
	logic signed [MW-1:0] m_s4, n_s4, p_s4, q_s4, s_s4, r_s4;
	rtiuv_pkg::tex_t tex_s2, tex_s3, tex_s4, tex_s5, tex_s6, tex_s7, tex_s8, tex_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			ogx_s1 <= pos_x;
			ogy_s1 <= pos_y;
			ogz_s1 <= pos_z;
			dx_s1  <= dir_x;
			dy_s1  <= dir_y;
			dz_s1  <= dir_z;

			ax_s2  <= FW'(v0_s1.px) - FW'(v1_s1.px);
			ay_s2  <= FW'(v0_s1.py) - FW'(v1_s1.py);
			az_s2  <= FW'(v0_s1.pz) - FW'(v1_s1.pz);
			bx_s2  <= FW'(v0_s1.px) - FW'(v2_s1.px);
			by_s2  <= FW'(v0_s1.py) - FW'(v2_s1.py);
			bz_s2  <= FW'(v0_s1.pz) - FW'(v2_s1.pz);
			ox_s2  <= FW'(v0_s1.px) - FW'(ogx_s1);
			oy_s2  <= FW'(v0_s1.py) - FW'(ogy_s1);
			oz_s2  <= FW'(v0_s1.pz) - FW'(ogz_s1);
			dx_s2  <= FW'(dx_s1);
			dy_s2  <= FW'(dy_s1);
			dz_s2  <= FW'(dz_s1);
			tex_s2 <= '{tu0: v0_s1.tu, tv0: v0_s1.tv, tu1: v1_s1.tu, tv1: v1_s1.tv,
				tu2: v2_s1.tu, tv2: v2_s1.tv};

			pr_s3[0]  <= by_s2 * dz_s2;
			pr_s3[1]  <= dy_s2 * bz_s2;
			pr_s3[2]  <= oy_s2 * dz_s2;
			pr_s3[3]  <= dy_s2 * oz_s2;
			pr_s3[4]  <= by_s2 * oz_s2;
			pr_s3[5]  <= oy_s2 * bz_s2;
			pr_s3[6]  <= dy_s2 * az_s2;
			pr_s3[7]  <= ay_s2 * dz_s2;
			pr_s3[8]  <= ay_s2 * bz_s2;
			pr_s3[9]  <= by_s2 * az_s2;
			pr_s3[10] <= ay_s2 * oz_s2;
			pr_s3[11] <= oy_s2 * az_s2;
			ax_s3  <= ax_s2;
			bx_s3  <= bx_s2;
			dx_s3  <= dx_s2;
			ox_s3  <= ox_s2;
			tex_s3 <= tex_s2;

			m_s4   <= MW'(pr_s3[0]) - MW'(pr_s3[1]);
			n_s4   <= MW'(pr_s3[2]) - MW'(pr_s3[3]);
			p_s4   <= MW'(pr_s3[4]) - MW'(pr_s3[5]);
			q_s4   <= MW'(pr_s3[6]) - MW'(pr_s3[7]);
			s_s4   <= MW'(pr_s3[8]) - MW'(pr_s3[9]);
			r_s4   <= MW'(pr_s3[10]) - MW'(pr_s3[11]);
			ax_s4  <= ax_s3;
			bx_s4  <= bx_s3;
			dx_s4  <= dx_s3;
			ox_s4  <= ox_s3;
			tex_s4 <= tex_s3;

			tex_s5 <= tex_s4;
			tex_s6 <= tex_s5;
			tex_s7 <= tex_s6;
			tex_s8 <= tex_s7;
			tex_s9 <= tex_s8;
		end
	end

	// determinant terms
	logic signed [AW-1:0] da [12];
	logic signed [BW-1:0] db [12];
	logic signed [XW-1:0] tp_s6 [12];

	assign da = '{ax_s4, bx_s4, dx_s4, ox_s4, bx_s4, dx_s4,
		ax_s4, ox_s4, dx_s4, ax_s4, bx_s4, ox_s4};
	assign db = '{BW'(m_s4), BW'(q_s4), BW'(s_s4), BW'(m_s4), BW'(n_s4), BW'(p_s4),
		BW'(n_s4), BW'(q_s4), BW'(r_s4), BW'(p_s4), BW'(r_s4), BW'(s_s4)};

	for (genvar g = 0; g < 12; g++) begin : g_det_mul
		rtiuv_mul u_mul (.clk(clk), .en(en), .a(da[g]), .b(db[g]), .p(tp_s6[g]));
	end

	logic signed [DW-1:0] den_s7, e1_s7, e2_s7, e3_s7;
	logic        [DW-1:0] den_s8;
	logic signed [DW-1:0] e1_s8, e2_s8, e3_s8;
	logic                 dzero_s8;
	logic signed [DW:0]   sum_s8;
	logic [SW-1:0]        lhs_s8, rhs_s8;
	logic        [DW-1:0] den_s9, wt_s9, den_s10, den_s11, den_s12;
	logic signed [DW-1:0] e1_s9, e2_s9;
	logic [NW-1:0]        nt_s9, nt_s10, nt_s11, nt_s12, nu_s12, nv_s12;
	logic                 miss_s9, sat_s9, miss_s10, sat_s10, miss_s11, sat_s11;
	rtiuv_pkg::meta_t     meta_s12;

	assign sum_s8 = (DW+1)'(e1_s8) + (DW+1)'(e2_s8);
	assign lhs_s8 = SW'(e3_s8[DW-1:0]) << rtiuv_pkg::FRAC_BITS;
	assign rhs_s8 = SW'(den_s8) << rtiuv_pkg::DIST_W;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s7   <= DW'(tp_s6[0] + tp_s6[1] + tp_s6[2]);
			e1_s7    <= DW'(tp_s6[3] - tp_s6[4] - tp_s6[5]);
			e2_s7    <= DW'(tp_s6[6] + tp_s6[7] + tp_s6[8]);
			e3_s7    <= DW'(tp_s6[9] - tp_s6[10] + tp_s6[11]);

			// orient so that the determinant is positive
			den_s8   <= den_s7[DW-1] ? DW'(-den_s7) : DW'(den_s7);
			e1_s8    <= den_s7[DW-1] ? -e1_s7 : e1_s7;
			e2_s8    <= den_s7[DW-1] ? -e2_s7 : e2_s7;
			e3_s8    <= den_s7[DW-1] ? -e3_s7 : e3_s7;
			dzero_s8 <= den_s7 == '0;

			miss_s9  <= dzero_s8 || e1_s8[DW-1] || e2_s8[DW-1] || e3_s8[DW-1]
				|| $signed({1'b0, den_s8}) < sum_s8;
			sat_s9   <= lhs_s8 >= rhs_s8;
			wt_s9    <= den_s8 - DW'(sum_s8);
			den_s9   <= den_s8;
			e1_s9    <= e1_s8;
			e2_s9    <= e2_s8;
			nt_s9    <= NW'(e3_s8[DW-1:0]) << rtiuv_pkg::FRAC_BITS;

			den_s10  <= den_s9;
			nt_s10   <= nt_s9;
			miss_s10 <= miss_s9;
			sat_s10  <= sat_s9;
			den_s11  <= den_s10;
			nt_s11   <= nt_s10;
			miss_s11 <= miss_s10;
			sat_s11  <= sat_s10;
		end
	end

	// texture blend products
	logic signed [AW-1:0] ta [6];
	logic signed [BW-1:0] tb [6];
	logic signed [XW-1:0] xp_s11 [6];

	assign ta = '{$signed(AW'(tex_s9.tu0)), $signed(AW'(tex_s9.tu1)), $signed(AW'(tex_s9.tu2)),
		$signed(AW'(tex_s9.tv0)), $signed(AW'(tex_s9.tv1)), $signed(AW'(tex_s9.tv2))};
	assign tb = '{$signed(wt_s9), e1_s9, e2_s9, $signed(wt_s9), e1_s9, e2_s9};

	for (genvar g = 0; g < 6; g++) begin : g_tex_mul
		rtiuv_mul u_mul (.clk(clk), .en(en), .a(ta[g]), .b(tb[g]), .p(xp_s11[g]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nu_s12  <= NW'(xp_s11[0] + xp_s11[1] + xp_s11[2]);
			nv_s12  <= NW'(xp_s11[3] + xp_s11[4] + xp_s11[5]);
			nt_s12  <= nt_s11;
			den_s12 <= den_s11;
		end
	end

	logic miss_s12_q, sat_s12_q;

	assign meta_s12 = '{vld: vld_s12, miss: miss_s12_q, sat: sat_s12_q};

	always_ff @(posedge clk) begin
		if (en) begin
			miss_s12_q <= miss_s11;
			sat_s12_q  <= sat_s11;
		end
	end

	// dividers
	logic [QW-1:0] qt, qu, qv;

	rtiuv_div u_div_t (.clk(clk), .en(en), .num(nt_s12), .den(den_s12), .quo(qt));
	rtiuv_div u_div_u (.clk(clk), .en(en), .num(nu_s12), .den(den_s12), .quo(qu));
	rtiuv_div u_div_v (.clk(clk), .en(en), .num(nv_s12), .den(den_s12), .quo(qv));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QW; i++) begin
				meta_q[i] <= '0;
			end
		end else if (en) begin
			meta_q[0] <= meta_s12;
			for (int i = 1; i < QW; i++) begin
				meta_q[i] <= meta_q[i-1];
			end
		end
	end

	// output word
	logic                         hit_d;
	logic                         hit_q;
	logic [rtiuv_pkg::DIST_W-1:0] dist_q;
	logic [rtiuv_pkg::TEX_W-1:0]  u_q, v_q;

	assign hit_d = !last.miss && (last.sat || qt >= min_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (en && last.vld) || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (en && last.vld) begin
			hit_q  <= hit_d;
			dist_q <= !hit_d ? '0 : (last.sat ? rtiuv_pkg::DIST_SAT : qt);
			u_q    <= hit_d ? qu[rtiuv_pkg::TEX_W-1:0] : '0;
			v_q    <= hit_d ? qv[rtiuv_pkg::TEX_W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign dist_t    = dist_q;
	assign hit_u     = u_q;
	assign hit_v     = v_q;

	// checks
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready && last.vld))
		else $error("input stalled without a blocked output word");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (dist_t == '0 && hit_u == '0 && hit_v == '0))
		else $error("miss word carries nonzero fields");

	a_hit_min: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (dist_t >= min_q))
		else $error("hit below minimum distance");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(meta_q[QW-1]))
		else $error("pipeline moved during a stall");

endmodule

// File: bench/rtiuv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtiuv_checker
// Watches the word, result and register ports of the ray / triangle block,
// keeps its own vertex store and distance floor, solves each test word by
// Cramer's rule in wide exact integers and compares every result field by
// field with the oldest prediction
// ----------------------------------------------------------------------------
module rtiuv_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [2:0]                           paddr,
	input  logic [31:0]                          pwdata,
	input  logic                                 pready,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic                                 req_type,
	input  logic [rtiuv_pkg::IDX_W-1:0]          idx0,
	input  logic [rtiuv_pkg::IDX_W-1:0]          idx1,
	input  logic [rtiuv_pkg::IDX_W-1:0]          idx2,
	input  logic signed [rtiuv_pkg::COORD_W-1:0] pos_x,
	input  logic signed [rtiuv_pkg::COORD_W-1:0] pos_y,
	input  logic signed [rtiuv_pkg::COORD_W-1:0] pos_z,
	input  logic signed [rtiuv_pkg::COORD_W-1:0] dir_x,
	input  logic signed [rtiuv_pkg::COORD_W-1:0] dir_y,
	input  logic signed [rtiuv_pkg::COORD_W-1:0] dir_z,
	input  logic [rtiuv_pkg::TEX_W-1:0]          tex_u,
	input  logic [rtiuv_pkg::TEX_W-1:0]          tex_v,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic                                 hit,
	input  logic [rtiuv_pkg::DIST_W-1:0]         dist_t,
	input  logic [rtiuv_pkg::TEX_W-1:0]          hit_u,
	input  logic [rtiuv_pkg::TEX_W-1:0]          hit_v,
	output int                                   errors,
	output int                                   outstanding
);

	typedef logic signed [255:0] wide_t;

	typedef struct packed {
		logic                         hit;
		logic [rtiuv_pkg::DIST_W-1:0] span;
		logic [rtiuv_pkg::TEX_W-1:0]  u;
		logic [rtiuv_pkg::TEX_W-1:0]  v;
	} hit_rec_t;

	logic signed [rtiuv_pkg::COORD_W-1:0] vx [rtiuv_pkg::VERTEX_COUNT];
	logic signed [rtiuv_pkg::COORD_W-1:0] vy [rtiuv_pkg::VERTEX_COUNT];
	logic signed [rtiuv_pkg::COORD_W-1:0] vz [rtiuv_pkg::VERTEX_COUNT];
	logic [rtiuv_pkg::TEX_W-1:0]          vu [rtiuv_pkg::VERTEX_COUNT];
	logic [rtiuv_pkg::TEX_W-1:0]          vv [rtiuv_pkg::VERTEX_COUNT];
	logic [rtiuv_pkg::DIST_W-1:0]         floor_dist;
	hit_rec_t                             hits_due [$];

	function automatic wide_t sx(logic signed [rtiuv_pkg::COORD_W-1:0] a);
		wide_t w;
		w = a;
		return w;
	endfunction

	function automatic wide_t zx(logic [rtiuv_pkg::TEX_W-1:0] a);
		wide_t w;
		w = {240'b0, a};
		return w;
	endfunction

	function automatic hit_rec_t trace_ray(int k0, int k1, int k2,
			logic signed [rtiuv_pkg::COORD_W-1:0] ox_i,
			logic signed [rtiuv_pkg::COORD_W-1:0] oy_i,
			logic signed [rtiuv_pkg::COORD_W-1:0] oz_i,
			logic signed [rtiuv_pkg::COORD_W-1:0] dx_i,
			logic signed [rtiuv_pkg::COORD_W-1:0] dy_i,
			logic signed [rtiuv_pkg::COORD_W-1:0] dz_i);
		wide_t ax, ay, az, bx, by, bz, dx, dy, dz, ox, oy, oz;
		wide_t m, n, p, q, s, r, den, e1, e2, e3, sum, wt, tq, lim, nu, nv;
		hit_rec_t res;
		res = '0;
		ax = sx(vx[k0]) - sx(vx[k1]); bx = sx(vx[k0]) - sx(vx[k2]);
		ay = sx(vy[k0]) - sx(vy[k1]); by = sx(vy[k0]) - sx(vy[k2]);
		az = sx(vz[k0]) - sx(vz[k1]); bz = sx(vz[k0]) - sx(vz[k2]);
		dx = sx(dx_i); dy = sx(dy_i); dz = sx(dz_i);
		ox = sx(vx[k0]) - sx(ox_i);
		oy = sx(vy[k0]) - sx(oy_i);
		oz = sx(vz[k0]) - sx(oz_i);
		m = by * dz - dy * bz;
		n = oy * dz - dy * oz;
		p = by * oz - oy * bz;
		q = dy * az - ay * dz;
		s = ay * bz - by * az;
		r = ay * oz - oy * az;
		den = ax * m + bx * q + dx * s;
		e1 = ox * m - bx * n - dx * p;
		e2 = ax * n + ox * q + dx * r;
		e3 = ax * p - bx * r + ox * s;
		if (den == 0)
			return res;
		if (den < 0) begin
			den = -den; e1 = -e1; e2 = -e2; e3 = -e3;
		end
		sum = e1 + e2;
		if (e1 < 0 || e2 < 0 || sum > den || e3 < 0)
			return res;
		tq = (e3 <<< rtiuv_pkg::FRAC_BITS) / den;
		lim = {225'b0, floor_dist};
		if (tq < lim)
			return res;
		wt = den - sum;
		nu = wt * zx(vu[k0]) + e1 * zx(vu[k1]) + e2 * zx(vu[k2]);
		nv = wt * zx(vv[k0]) + e1 * zx(vv[k1]) + e2 * zx(vv[k2]);
		res.hit = 1'b1;
		res.span = (tq > 256'sh7fffffff) ? rtiuv_pkg::DIST_SAT : tq[rtiuv_pkg::DIST_W-1:0];
		nu = nu / den;
		nv = nv / den;
		res.u = nu[rtiuv_pkg::TEX_W-1:0];
		res.v = nv[rtiuv_pkg::TEX_W-1:0];
		return res;
	endfunction

	task automatic report(string what);
		$display("%0t mismatch: %s", $time, what);
		errors++;
	endtask

	assign outstanding = hits_due.size();

	always @(posedge clk or negedge arst_n) begin
		hit_rec_t want;
		if (!arst_n) begin
			floor_dist <= rtiuv_pkg::MIN_DIST_RESET;
			hits_due.delete();
		end else begin
			if (psel && penable && pwrite && pready
					&& paddr == {rtiuv_pkg::REG_MIN_DISTANCE, 2'b00})
				floor_dist <= pwdata[rtiuv_pkg::DIST_W-1:0];
			if (in_valid && in_ready) begin
				if (req_type == rtiuv_pkg::REQ_LOAD) begin
					vx[idx0] = pos_x; vy[idx0] = pos_y; vz[idx0] = pos_z;
					vu[idx0] = tex_u; vv[idx0] = tex_v;
				end else begin
					hits_due.push_back(trace_ray(idx0, idx1, idx2, pos_x, pos_y, pos_z,
						dir_x, dir_y, dir_z));
				end
			end
			if (out_valid && out_ready) begin
				if (hits_due.size() == 0) begin
					report("result word with none expected");
				end else begin
					want = hits_due.pop_front();
					if (hit !== want.hit)
						report($sformatf("hit %b, expected %b", hit, want.hit));
					if (dist_t !== want.span)
						report($sformatf("dist_t %h, expected %h", dist_t, want.span));
					if (hit_u !== want.u)
						report($sformatf("hit_u %h, expected %h", hit_u, want.u));
					if (hit_v !== want.v)
						report($sformatf("hit_v %h, expected %h", hit_v, want.v));
				end
			end
		end
	end
endmodule

// File: bench/tb_ray_triangle_intersect_uv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_triangle_intersect_uv
// Loads vertices and fires rays at triangles: directed corner and miss cases,
// then phases of random words, mostly rays aimed inside stored triangles,
// under several distance floors, idling and stall mixes; the checker predicts and
// compares, this module drives and gives the verdict
// ----------------------------------------------------------------------------
module tb_ray_triangle_intersect_uv;

	localparam int LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic in_valid = 1'b0, in_ready;
	logic req_type = rtiuv_pkg::REQ_LOAD;
	logic [rtiuv_pkg::IDX_W-1:0] idx0 = '0, idx1 = '0, idx2 = '0;
	logic signed [rtiuv_pkg::COORD_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [rtiuv_pkg::COORD_W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic [rtiuv_pkg::TEX_W-1:0] tex_u = '0, tex_v = '0;
	logic out_valid, out_ready = 1'b1, hit;
	logic [rtiuv_pkg::DIST_W-1:0] dist_t;
	logic [rtiuv_pkg::TEX_W-1:0] hit_u, hit_v;
	int errors, outstanding, cycles = 0;
	int idle_pct = 0, stall_pct = 0;

	logic signed [rtiuv_pkg::COORD_W-1:0] px_m [rtiuv_pkg::VERTEX_COUNT];
	logic signed [rtiuv_pkg::COORD_W-1:0] py_m [rtiuv_pkg::VERTEX_COUNT];
	logic signed [rtiuv_pkg::COORD_W-1:0] pz_m [rtiuv_pkg::VERTEX_COUNT];
	bit loaded [rtiuv_pkg::VERTEX_COUNT];
	int loaded_q [$];

	ray_triangle_intersect_uv u_top (.*);

	rtiuv_checker u_chk (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_ray_triangle_intersect_uv: done, errors");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	task automatic push(logic rt, int i0, int i1, int i2,
			logic signed [31:0] ox, logic signed [31:0] oy, logic signed [31:0] oz,
			logic signed [31:0] dx, logic signed [31:0] dy, logic signed [31:0] dz,
			logic [15:0] tu, logic [15:0] tv);
		in_valid <= 1'b1; req_type <= rt;
		idx0 <= rtiuv_pkg::IDX_W'(i0);
		idx1 <= rtiuv_pkg::IDX_W'(i1);
		idx2 <= rtiuv_pkg::IDX_W'(i2);
		pos_x <= ox; pos_y <= oy; pos_z <= oz;
		dir_x <= dx; dir_y <= dy; dir_z <= dz;
		tex_u <= tu; tex_v <= tv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < idle_pct) @(negedge clk);
		end
	endtask

	task automatic load(int k, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic [15:0] tu, logic [15:0] tv);
		push(rtiuv_pkg::REQ_LOAD, k, int'($urandom_range(1023)), int'($urandom_range(1023)),
			x, y, z, $urandom, $urandom, $urandom, tu, tv);
		px_m[k] = x; py_m[k] = y; pz_m[k] = z;
		if (!loaded[k]) begin
			loaded[k] = 1'b1;
			loaded_q.push_back(k);
		end
	endtask

	task automatic probe(int i0, int i1, int i2, logic signed [31:0] ox,
			logic signed [31:0] oy, logic signed [31:0] oz, logic signed [31:0] dx,
			logic signed [31:0] dy, logic signed [31:0] dz);
		push(rtiuv_pkg::REQ_TEST, i0, i1, i2, ox, oy, oz, dx, dy, dz,
			16'($urandom), 16'($urandom));
	endtask

	task automatic set_floor(logic [31:0] val);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {rtiuv_pkg::REG_MIN_DISTANCE, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	function automatic logic signed [31:0] rnd_coord();
		if ($urandom_range(9) == 0)
			return $urandom;
		return $signed($urandom_range(8388608)) - 32'sd4194304;
	endfunction

	task automatic random_word();
		int k0, k1, k2, a, b, c, sh;
		longint tx, ty, tz, ox, oy, oz;
		if ($urandom_range(99) < 20 || loaded_q.size() < 3) begin
			load(int'($urandom_range(1023)), rnd_coord(), rnd_coord(), rnd_coord(),
				16'($urandom), 16'($urandom));
		end else begin
			k0 = loaded_q[$urandom_range(loaded_q.size() - 1)];
			k1 = loaded_q[$urandom_range(loaded_q.size() - 1)];
			k2 = loaded_q[$urandom_range(loaded_q.size() - 1)];
			if ($urandom_range(99) < 15) begin
				probe(k0, k1, k2, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else begin
				a = $urandom_range(4); b = $urandom_range(4); c = $urandom_range(4) + 1;
				tx = (a * longint'(px_m[k0]) + b * longint'(px_m[k1]) + c * longint'(px_m[k2]))
					/ (a + b + c);
				ty = (a * longint'(py_m[k0]) + b * longint'(py_m[k1]) + c * longint'(py_m[k2]))
					/ (a + b + c);
				tz = (a * longint'(pz_m[k0]) + b * longint'(pz_m[k1]) + c * longint'(pz_m[k2]))
					/ (a + b + c);
				ox = tx + rnd_coord(); oy = ty + rnd_coord(); oz = tz + rnd_coord();
				sh = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(2);
				probe(k0, k1, k2, 32'(ox), 32'(oy), 32'(oz), 32'((tx - ox) >>> sh),
					32'((ty - oy) >>> sh), 32'((tz - oz) >>> sh));
			end
		end
	endtask

	initial begin
		logic [31:0] floors [5];
		int idles [5], stalls [5];
		floors = '{32'd0, 32'd65536, 32'h7fffffff, 32'd40000, 32'd7};
		idles = '{0, 80, 0, 36, 0};
		stalls = '{0, 0, 80, 36, 0};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// unit triangle in the xy plane, plus extreme vertices
		load(0, 0, 0, 0, 16'h0000, 16'h0000);
		load(1, 65536, 0, 0, 16'hffff, 16'h0000);
		load(2, 0, 65536, 0, 16'h0000, 16'hffff);
		load(1023, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'hffff, 16'hffff);
		load(512, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'h5555, 16'haaaa);
		load(341, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 16'h1234, 16'hfedc);
		probe(0, 1, 2, 16384, 16384, -65536, 0, 0, 65536);
		probe(0, 1, 2, -16384, 16384, -65536, 0, 0, 65536);
		probe(0, 1, 2, 16384, -16384, -65536, 0, 0, 65536);
		probe(0, 1, 2, 60000, 60000, -65536, 0, 0, 65536);
		probe(0, 0, 1, 16384, 16384, -65536, 0, 0, 65536);
		probe(0, 1, 2, 16384, 16384, -65536, 65536, 0, 0);
		probe(0, 1, 2, 16384, 16384, -65536, 0, 0, -65536);
		probe(0, 1, 2, 16384, 16384, -65536, 0, 0, 1);
		probe(0, 1, 2, 0, 0, -65536, 0, 0, 65536);
		probe(0, 1, 2, 65536, 0, 65536, 0, 0, -65536);
		probe(0, 1, 2, 16384, 16384, -4, 0, 0, 65536);
		probe(1023, 512, 341, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		probe(1023, 512, 341, 32'sh80000000, 32'sh7fffffff, 0, 32'sh80000000,
			32'sh80000000, 32'sh80000000);
		probe(1023, 512, 0, -1, -1, -1, -1, -1, -1);
		for (int ph = 0; ph < 5; ph++) begin
			set_floor(floors[ph]);
			idle_pct = idles[ph];
			stall_pct = stalls[ph];
			repeat (326) random_word();
		end
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("tb_ray_triangle_intersect_uv: done, clean");
		else
			$display("tb_ray_triangle_intersect_uv: done, errors");
		$finish;
	end
endmodule
